FILE: rtl/core/lbpc_pkg.sv
`timescale 1ns / 1ps
// lbpc_pkg: types, codes and constants of the LED blink pattern controller.
// No dependencies; used by the channel interfaces and the core.
package lbpc_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_COMMAND  = 2'd1;
    localparam logic [1:0] OP_IDENTIFY = 2'd2;

    // Command codes
    localparam logic [7:0] CMD_OFF      = 8'd0;
    localparam logic [7:0] CMD_ONESHOT  = 8'd1;
    localparam logic [7:0] CMD_IDENTIFY = 8'd2;
    localparam logic [7:0] CMD_CUSTOM   = 8'd3;

    // One-shot presets
    localparam logic [7:0] PRESET_3X100 = 8'd1;
    localparam logic [7:0] PRESET_2X300 = 8'd2;

    // Timing (ms) and counts
    localparam logic [15:0] IDENT_HALF        = 16'd250;
    localparam logic [15:0] PRESET_A_HALF     = 16'd100;
    localparam logic [15:0] PRESET_B_HALF     = 16'd300;
    localparam logic [15:0] DEFAULT_HALF      = 16'd200;
    localparam logic [15:0] CUSTOM_HALF       = 16'd200;
    localparam logic [7:0]  IDENT_COUNT       = 8'hFF;
    localparam logic [7:0]  PRESET_A_COUNT    = 8'd3;
    localparam logic [7:0]  PRESET_B_COUNT    = 8'd2;
    localparam logic [7:0]  ONESHOT_COUNT     = 8'd1;
    localparam logic [7:0]  CUSTOM_ZERO_COUNT = 8'd3;

    // dur / 200 = (dur >> 3) / 25; 1/25 taken as 5243 / 2^17, exact for 13-bit values
    localparam logic [12:0] RECIP_25 = 13'd5243;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_IDENTIFY = 2'd1,
        MODE_PATTERN  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  command_code;
        logic [15:0] duration_arg;
        logic [7:0]  pattern_select;
        logic        identify_enable;
    } t_in_item;

    typedef struct packed {
        logic       led_on;
        logic [1:0] mode_now;
        logic [7:0] blinks_left;
    } t_out_item;

    // Blink count of a custom command: low 8 bits of dur / 200
    function automatic logic [7:0] div200(input logic [15:0] dur);
        logic [12:0] x;
        logic [25:0] p;
        x = dur[15:3];
        p = x * RECIP_25;
        return p[24:17];
    endfunction

endpackage

FILE: rtl/core/lbpc_if.sv
`timescale 1ns / 1ps
// lbpc_if: valid/ready channels for input and result words.
// Depends on lbpc_pkg for the payload types.
interface lbpc_in_if;
    import lbpc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbpc_out_if;
    import lbpc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/led_blink_pattern_controller_core.sv
`timescale 1ns / 1ps
// led_blink_pattern_controller_core: one-LED blink controller, ticks and commands in.
// Depends on lbpc_pkg and the channel interfaces in lbpc_if.sv.
//
//   channel | dir | payload                                              | handshake
//   i_in    | in  | operation, command_code, duration_arg,               | valid/ready
//           |     | pattern_select, identify_enable                      |
//   o_out   | out | led_on, mode_now, blinks_left                        | valid/ready
//
// One word per cycle unless o_out stalls: a word is taken into the state registers
// in the cycle it is accepted, and its result is shown the next cycle from them.
// The longest path is the custom-count multiply (13x13) feeding the count register.
// i_in.ready stays high while the result register is empty or being drained, so a
// stalled o_out holds one result and blocks the input only until it is taken.
// Synchronous active-low reset: mode off, LED off, counters and timers cleared.
module led_blink_pattern_controller_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lbpc_in_if.sink           i_in,
    lbpc_out_if.source        o_out
);
    import lbpc_pkg::*;

    // State (also the result register)
    t_mode       r_mode,      n_mode;
    logic        r_led,       n_led;
    logic [7:0]  r_count,     n_count;
    logic [15:0] r_half,      n_half;
    logic [15:0] r_countdown, n_countdown;
    logic        r_out_valid, n_out_valid;

    // Decoded word
    logic        w_accept;
    logic        w_start;
    logic        w_off;
    logic        w_tick;
    t_mode       w_start_mode;
    logic [7:0]  w_start_count;
    logic [15:0] w_start_half;
    logic [7:0]  w_custom_q;
    logic [7:0]  w_count_dec;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_custom_q = div200(i_in.data.duration_arg);

    // Decode: which phase a word starts, or whether it turns the LED off / ticks
    always_comb begin
        w_start       = 1'b0;
        w_off         = 1'b0;
        w_tick        = 1'b0;
        w_start_mode  = MODE_PATTERN;
        w_start_count = ONESHOT_COUNT;
        w_start_half  = DEFAULT_HALF;
        case (i_in.data.operation)
            OP_TICK: begin
                w_tick = 1'b1;
            end
            OP_COMMAND: begin
                case (i_in.data.command_code)
                    CMD_OFF: begin
                        w_off = 1'b1;
                    end
                    CMD_ONESHOT: begin
                        w_start = 1'b1;
                        if (i_in.data.pattern_select == PRESET_3X100) begin
                            w_start_count = PRESET_A_COUNT;
                            w_start_half  = PRESET_A_HALF;
                        end else if (i_in.data.pattern_select == PRESET_2X300) begin
                            w_start_count = PRESET_B_COUNT;
                            w_start_half  = PRESET_B_HALF;
                        end else if (i_in.data.duration_arg != 16'd0) begin
                            w_start_half  = i_in.data.duration_arg;
                        end
                    end
                    CMD_IDENTIFY: begin
                        w_start       = 1'b1;
                        w_start_mode  = MODE_IDENTIFY;
                        w_start_count = IDENT_COUNT;
                        w_start_half  = IDENT_HALF;
                    end
                    CMD_CUSTOM: begin
                        w_start       = 1'b1;
                        w_start_count = (w_custom_q == 8'd0) ? CUSTOM_ZERO_COUNT
                                                             : w_custom_q;
                        w_start_half  = CUSTOM_HALF;
                    end
                    default: ;
                endcase
            end
            OP_IDENTIFY: begin
                if (i_in.data.identify_enable) begin
                    w_start       = 1'b1;
                    w_start_mode  = MODE_IDENTIFY;
                    w_start_count = IDENT_COUNT;
                    w_start_half  = IDENT_HALF;
                end else begin
                    w_off = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Count after an on-to-off edge, saturating at zero
    assign w_count_dec = (r_count != 8'd0) ? (r_count - 8'd1) : 8'd0;

    // Next state
    always_comb begin
        n_mode      = r_mode;
        n_led       = r_led;
        n_count     = r_count;
        n_half      = r_half;
        n_countdown = r_countdown;
        if (w_accept) begin
            if (w_start) begin
                n_mode      = w_start_mode;
                n_count     = w_start_count;
                n_half      = w_start_half;
                n_countdown = w_start_half;
                n_led       = 1'b1;
            end else if (w_off) begin
                n_mode = MODE_OFF;
                n_led  = 1'b0;
            end else if (w_tick && (r_mode != MODE_OFF)) begin
                if (r_countdown > 16'd1) begin
                    n_countdown = r_countdown - 16'd1;
                end else begin
                    n_countdown = r_half;
                    n_led       = !r_led;
                    // end of an on phase in a pattern uses up one blink
                    if ((r_mode == MODE_PATTERN) && r_led) begin
                        n_count = w_count_dec;
                        if (w_count_dec == 8'd0) begin
                            n_mode = MODE_OFF;
                        end
                    end
                end
            end
        end
    end

    // Result register occupancy
    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_OFF;
            r_led       <= 1'b0;
            r_count     <= 8'd0;
            r_half      <= 16'd0;
            r_countdown <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_led       <= n_led;
            r_count     <= n_count;
            r_half      <= n_half;
            r_countdown <= n_countdown;
            r_out_valid <= n_out_valid;
        end
    end

    // Outputs: state only moves on accept, so the registers hold the pending result
    assign o_out.valid            = r_out_valid;
    assign o_out.data.led_on      = r_led;
    assign o_out.data.mode_now    = r_mode;
    assign o_out.data.blinks_left = r_count;

    // Checks
    a_identify_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.data.operation == OP_IDENTIFY) && i_in.data.identify_enable)
        |=> ((r_mode == MODE_IDENTIFY) && (r_count == IDENT_COUNT) && r_led))
        else $error("set identify did not start identify");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OFF) |-> !r_led)
        else $error("LED lit while mode is off");

    a_identify_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDENTIFY) |-> (r_count == IDENT_COUNT))
        else $error("blink count moved in identify mode");

    a_countdown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_countdown <= r_half)
        else $error("countdown above half period");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for led_blink_pattern_controller_core.
// Needs lbpc_pkg, the channel interfaces of lbpc_if.sv and the core; checks every result word.
module tb;
    import lbpc_pkg::*;

    // Operation code 3 carries no operation; the block must leave its state alone
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 575;
    localparam int MAX_SHOWN    = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lbpc_in_if  in_ch ();
    lbpc_out_if out_ch ();

    led_blink_pattern_controller_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted LED state
    t_mode       exp_mode;
    logic        exp_led;
    logic [7:0]  exp_blinks;
    logic [15:0] exp_half;
    logic [15:0] exp_countdown;

    t_out_item   led_state_q [$];

    bit idle_on       = 1'b1;
    int hold_cycles   = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void begin_blink(t_mode m, logic [7:0] n, logic [15:0] half);
        exp_mode      = m;
        exp_blinks    = n;
        exp_half      = half;
        exp_countdown = half;
        exp_led       = 1'b1;
    endfunction

    function automatic void led_off();
        exp_mode = MODE_OFF;
        exp_led  = 1'b0;
    endfunction

    function automatic t_out_item next_led_state(t_in_item w);
        t_out_item   r;
        logic [15:0] quot;
        logic [7:0]  n;
        case (w.operation)
            OP_TICK: begin
                if (exp_mode != MODE_OFF) begin
                    if (exp_countdown > 16'd1) begin
                        exp_countdown = exp_countdown - 16'd1;
                    end else begin
                        exp_countdown = exp_half;
                        exp_led       = ~exp_led;
                        // on-to-off edge closes one blink in pattern mode
                        if (exp_mode == MODE_PATTERN && !exp_led) begin
                            if (exp_blinks != 8'd0) exp_blinks = exp_blinks - 8'd1;
                            if (exp_blinks == 8'd0) led_off();
                        end
                    end
                end
            end
            OP_COMMAND: begin
                case (w.command_code)
                    CMD_OFF: begin
                        led_off();
                    end
                    CMD_ONESHOT: begin
                        if (w.pattern_select == PRESET_3X100)
                            begin_blink(MODE_PATTERN, 8'd3, 16'd100);
                        else if (w.pattern_select == PRESET_2X300)
                            begin_blink(MODE_PATTERN, 8'd2, 16'd300);
                        else
                            begin_blink(MODE_PATTERN, 8'd1,
                                        (w.duration_arg != 16'd0) ? w.duration_arg : 16'd200);
                    end
                    CMD_IDENTIFY: begin
                        begin_blink(MODE_IDENTIFY, 8'hFF, 16'd250);
                    end
                    CMD_CUSTOM: begin
                        quot = w.duration_arg / 16'd200;
                        n    = quot[7:0];
                        if (n == 8'd0) n = 8'd3;
                        begin_blink(MODE_PATTERN, n, 16'd200);
                    end
                    default: begin
                    end
                endcase
            end
            OP_IDENTIFY: begin
                if (w.identify_enable) begin_blink(MODE_IDENTIFY, 8'hFF, 16'd250);
                else led_off();
            end
            default: begin
            end
        endcase
        r.led_on      = exp_led;
        r.mode_now    = exp_mode;
        r.blinks_left = exp_blinks;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------
    function automatic t_in_item make_word(logic [1:0] op, logic [7:0] code, logic [15:0] dur,
                                           logic [7:0] sel, logic en);
        t_in_item w;
        w.operation       = op;
        w.command_code    = code;
        w.duration_arg    = dur;
        w.pattern_select  = sel;
        w.identify_enable = en;
        return w;
    endfunction

    function automatic t_in_item any_word();
        t_in_item w;
        w.operation       = 2'($urandom_range(0, 3));
        w.command_code    = 8'($urandom_range(0, 255));
        w.duration_arg    = 16'($urandom_range(0, 65535));
        w.pattern_select  = 8'($urandom_range(0, 255));
        w.identify_enable = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // tick with random contents in the fields a tick ignores
    function automatic t_in_item tick_word();
        t_in_item w;
        w = any_word();
        w.operation = OP_TICK;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one word, optional idle gap first; prediction on acceptance
    // ------------------------------------------------------------------
    task automatic send_word(t_in_item w);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = w;
        do @(posedge i_clk); while (!in_ch.ready);
        led_state_q.push_back(next_led_state(w));
        words_sent++;
    endtask

    task automatic send_cmd(logic [7:0] code, logic [15:0] dur, logic [7:0] sel);
        send_word(make_word(OP_COMMAND, code, dur, sel, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(tick_word());
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long hold when asked
    // ------------------------------------------------------------------
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (hold_cycles - 1) @(negedge i_clk);
                hold_cycles = 0;
            end
            gap = idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Result check against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (led_state_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("[%0t] unexpected result word: led %0b mode %0d blinks %0d",
                             $time, out_ch.data.led_on, out_ch.data.mode_now,
                             out_ch.data.blinks_left);
            end else begin
                want = led_state_q.pop_front();
                words_checked++;
                if (want.led_on !== out_ch.data.led_on ||
                    want.mode_now !== out_ch.data.mode_now ||
                    want.blinks_left !== out_ch.data.blinks_left) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"[%0t] word %0d: exp led %0b mode %0d blinks %0d,",
                                  " got led %0b mode %0d blinks %0d"},
                                 $time, words_checked, want.led_on, want.mode_now,
                                 want.blinks_left, out_ch.data.led_on, out_ch.data.mode_now,
                                 out_ch.data.blinks_left);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, led_state_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // field extremes, every operation and command, ignored words, count corners
    task automatic test_corner_words();
        send_word(make_word(OP_TICK, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));     // tick while off
        send_word(make_word(OP_NOP, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));      // no operation
        send_cmd(8'hFF, 16'hFFFF, 8'hFF);                                // unknown code
        send_cmd(8'd4, 16'd0, 8'd0);                                     // unknown code
        send_cmd(CMD_ONESHOT, 16'd0, PRESET_3X100);
        send_word(make_word(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0));
        send_word(make_word(OP_NOP, 8'd0, 16'd0, 8'd0, 1'b0));           // held during pattern
        send_cmd(CMD_ONESHOT, 16'hFFFF, PRESET_2X300);
        send_cmd(CMD_ONESHOT, 16'd0, 8'd0);                              // default 200 ms
        send_cmd(CMD_ONESHOT, 16'hFFFF, 8'hFF);
        send_cmd(CMD_IDENTIFY, 16'd0, 8'd0);
        send_cmd(CMD_CUSTOM, 16'd0, 8'd0);                               // zero count -> 3
        send_cmd(CMD_CUSTOM, 16'd199, 8'd0);
        send_cmd(CMD_CUSTOM, 16'd200, 8'hFF);
        send_cmd(CMD_CUSTOM, 16'd51200, 8'd0);                           // 256 truncates to 0
        send_cmd(CMD_CUSTOM, 16'hFFFF, 8'd0);
        send_word(make_word(OP_IDENTIFY, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));
        send_word(make_word(OP_IDENTIFY, 8'd0, 16'd0, 8'd0, 1'b0));
        send_cmd(CMD_ONESHOT, 16'd1, 8'd0);                              // 1 ms phases
        send_ticks(1);                                                   // last blink ends
        send_ticks(1);                                                   // tick while off
        send_cmd(CMD_IDENTIFY, 16'd0, 8'd0);
        send_cmd(CMD_OFF, 16'hFFFF, 8'hFF);
    endtask

    // full preset and identify phases, back to back with no idling
    task automatic test_long_phases();
        idle_on = 1'b0;
        send_cmd(CMD_ONESHOT, 16'd0, PRESET_3X100);
        send_ticks(503);
        send_cmd(CMD_IDENTIFY, 16'd0, 8'd0);
        send_ticks(505);
        send_cmd(CMD_ONESHOT, 16'd0, PRESET_2X300);
        send_ticks(310);
        send_cmd(CMD_OFF, 16'd0, 8'd0);
        idle_on = 1'b1;
    endtask

    // long output hold while the input keeps offering words
    task automatic test_input_stall();
        idle_on = 1'b0;
        hold_cycles = 80;
        send_cmd(CMD_ONESHOT, 16'd3, 8'd0);
        repeat (30) send_word(($urandom_range(0, 3) == 0) ? any_word() : tick_word());
        idle_on = 1'b1;
    endtask

    // mostly well-formed blink sequences with random content, some noise
    task automatic test_random_sequences();
        int start;
        int kind;
        int dur;
        int n;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                // short one-shot with a random number of ticks, noise sprinkled in
                dur = $urandom_range(1, 6);
                send_cmd(CMD_ONESHOT, 16'(dur), 8'($urandom_range(0, 255)));
                n = $urandom_range(0, 2 * dur + 3);
                repeat (n) send_word(($urandom_range(0, 7) == 0) ? any_word() : tick_word());
            end else if (kind <= 5) begin
                send_cmd(CMD_CUSTOM, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
                send_ticks($urandom_range(0, 5));
                if ($urandom_range(0, 1))
                    send_cmd(CMD_OFF, 16'($urandom_range(0, 65535)), 8'd0);
            end else if (kind == 6) begin
                if ($urandom_range(0, 1))
                    send_cmd(CMD_IDENTIFY, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)));
                else
                    send_word(make_word(OP_IDENTIFY, 8'($urandom_range(0, 255)),
                                        16'($urandom_range(0, 65535)),
                                        8'($urandom_range(0, 255)), 1'b1));
                send_ticks($urandom_range(0, 6));
                if ($urandom_range(0, 1))
                    send_word(make_word(OP_IDENTIFY, 8'($urandom_range(0, 255)),
                                        16'($urandom_range(0, 65535)),
                                        8'($urandom_range(0, 255)), 1'b0));
                else
                    send_cmd(CMD_OFF, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) send_word(any_word());
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        exp_mode      = MODE_OFF;
        exp_led       = 1'b0;
        exp_blinks    = 8'd0;
        exp_half      = 16'd0;
        exp_countdown = 16'd0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_words();
        test_long_phases();
        test_input_stall();
        test_random_sequences();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (led_state_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display({"sent %0d words (corners, full preset and identify phases,",
                  " output hold, random runs)"}, words_sent);
        $display("checked %0d result words, %0d mismatches, %0d cycles",
                 words_checked, mismatches, cycle_count);
        if (mismatches == 0 && led_state_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
